[rtl/core/pcpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and constants of the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int PAGE_W    = 10;
  localparam int CPU_W     = 3;
  localparam int LIMIT_W   = 11;
  localparam int BATCH_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  // Wide enough to compare any page or requester against the size parameters.
  localparam int PCMP_W    = 17;
  localparam int CCMP_W    = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL_BATCH = 2'd2;

  localparam logic [PAGE_W-1:0]  FIRST_PAGE_RST  = 10'd0;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST  = 11'd1024;
  localparam logic [BATCH_W-1:0] STEAL_BATCH_RST = 11'd64;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  first_page;
    logic [LIMIT_W-1:0] page_limit;
    logic [BATCH_W-1:0] steal_batch;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    status_t           status;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/pcpa_link_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_link_ram
// Next-page link memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcpa_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/pcpa_head_file.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_head_file
// List head per requester, one read and one write port, reset to list end.
// ----------------------------------------------------------------------------
module pcpa_head_file #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 1024,
  parameter int CW        = 3,
  parameter int LW        = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [CW-1:0] rd_idx,
  output logic      [LW-1:0] rd_head,
  input  wire logic          wr_en,
  input  wire logic [CW-1:0] wr_idx,
  input  wire logic [LW-1:0] wr_head
);

  localparam logic [LW-1:0] LIST_END = LW'(NUM_PAGES);

  logic [LW-1:0] head_r [NUM_CPUS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (!rst_n) begin
        head_r[i] <= LIST_END;
      end else if (wr_en && (wr_idx == CW'(i))) begin
        head_r[i] <= wr_head;
      end
    end
  end

  // Indexes beyond the last requester never occur; they read as list end.
  always_comb begin
    rd_head = LIST_END;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (rd_idx == CW'(i)) begin
        rd_head = head_r[i];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/pcpa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_seq
// Sequencer: free, pop, donor scan and page-by-page steal over the head
// file and the link memory.
// ----------------------------------------------------------------------------
module pcpa_seq #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 1024,
  parameter int CW        = 3,
  parameter int PW        = 10,
  parameter int LW        = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_accept,
  input  wire logic                      in_operation,
  input  wire logic [pcpa_pkg::CPU_W-1:0]  in_requester,
  input  wire logic [pcpa_pkg::PAGE_W-1:0] in_page_number,
  input  wire pcpa_pkg::cfg_t            cfg,
  output logic                           idle,
  input  wire logic                      res_free,
  output logic                           res_valid,
  output pcpa_pkg::res_t                 res,
  output logic [CW-1:0]                  hd_rd_idx,
  input  wire logic [LW-1:0]             hd_rd_head,
  output logic                           hd_wr_en,
  output logic [CW-1:0]                  hd_wr_idx,
  output logic [LW-1:0]                  hd_wr_head,
  output logic                           lk_rd_en,
  output logic [PW-1:0]                  lk_rd_addr,
  input  wire logic [LW-1:0]             lk_rd_data,
  output logic                           lk_wr_en,
  output logic [PW-1:0]                  lk_wr_addr,
  output logic [LW-1:0]                  lk_wr_data
);
  import pcpa_pkg::*;

  localparam logic [LW-1:0] LIST_END = LW'(NUM_PAGES);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_STEAL_CHK, S_STEAL_MV, S_POP_RD, S_POP_WB, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic                 op_r;
  logic [CPU_W-1:0]     req_r;
  logic [PAGE_W-1:0]    page_r;
  logic [LW-1:0]        req_head_r, req_head_nxt;
  logic [LW-1:0]        don_head_r, don_head_nxt;
  logic [CW-1:0]        don_r, don_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [BATCH_W-1:0]   left_r, left_nxt;
  res_t                 res_r, res_nxt;

  logic                 cpu_ok;
  logic                 page_ok;
  logic [CW-1:0]        cpu_idx;
  logic [LW-1:0]        link_clip;

  function automatic logic is_page(input logic [LW-1:0] v);
    return v < LIST_END;
  endfunction

  assign cpu_idx   = CW'(req_r);
  assign cpu_ok    = CCMP_W'(req_r) < CCMP_W'(NUM_CPUS);
  assign page_ok   = (page_r >= cfg.first_page) &&
                     ({1'b0, page_r} < cfg.page_limit) &&
                     (PCMP_W'(page_r) < PCMP_W'(NUM_PAGES));
  // A corrupt link beyond the last page ends the list.
  assign link_clip = is_page(lk_rd_data) ? lk_rd_data : LIST_END;

  always_comb begin
    state_nxt    = state_r;
    req_head_nxt = req_head_r;
    don_head_nxt = don_head_r;
    don_nxt      = don_r;
    scan_nxt     = scan_r;
    left_nxt     = left_r;
    res_nxt      = res_r;
    hd_rd_idx    = (state_r == S_SCAN) ? scan_r : cpu_idx;
    hd_wr_en     = 1'b0;
    hd_wr_idx    = cpu_idx;
    hd_wr_head   = LIST_END;
    lk_rd_en     = 1'b0;
    lk_rd_addr   = don_head_r[PW-1:0];
    lk_wr_en     = 1'b0;
    lk_wr_addr   = don_head_r[PW-1:0];
    lk_wr_data   = req_head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt.granted_page = '0;
        res_nxt.status       = STAT_OK;
        state_nxt            = S_DONE;
        if (op_r == OP_FREE) begin
          if (!cpu_ok || !page_ok) begin
            res_nxt.status = STAT_RANGE;
          end else begin
            lk_wr_en   = 1'b1;
            lk_wr_addr = PW'(page_r);
            lk_wr_data = hd_rd_head;
            hd_wr_en   = 1'b1;
            hd_wr_head = LW'(page_r);
          end
        end else if (!cpu_ok) begin
          res_nxt.status = STAT_OOM;
        end else begin
          req_head_nxt = hd_rd_head;
          scan_nxt     = '0;
          state_nxt    = is_page(hd_rd_head) ? S_POP_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if ((scan_r != cpu_idx) && is_page(hd_rd_head)) begin
          don_nxt      = scan_r;
          don_head_nxt = hd_rd_head;
          left_nxt     = cfg.steal_batch;
          state_nxt    = S_STEAL_CHK;
        end else if (scan_r == CW'(NUM_CPUS - 1)) begin
          state_nxt = S_POP_RD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_STEAL_CHK: begin
        if ((left_r != '0) && is_page(don_head_r)) begin
          lk_rd_en  = 1'b1;
          state_nxt = S_STEAL_MV;
        end else begin
          hd_wr_en   = 1'b1;
          hd_wr_idx  = don_r;
          hd_wr_head = don_head_r;
          state_nxt  = S_POP_RD;
        end
      end
      S_STEAL_MV: begin
        // Move the donor's head page onto the requester's list.
        lk_wr_en     = 1'b1;
        don_head_nxt = link_clip;
        req_head_nxt = don_head_r;
        left_nxt     = left_r - 1'b1;
        state_nxt    = S_STEAL_CHK;
      end
      S_POP_RD: begin
        if (is_page(req_head_r)) begin
          lk_rd_en   = 1'b1;
          lk_rd_addr = req_head_r[PW-1:0];
          state_nxt  = S_POP_WB;
        end else begin
          res_nxt.status = STAT_OOM;
          state_nxt      = S_DONE;
        end
      end
      S_POP_WB: begin
        hd_wr_en             = 1'b1;
        hd_wr_head           = link_clip;
        res_nxt.granted_page = PAGE_W'(req_head_r);
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (in_accept && (state_r == S_IDLE)) begin
      op_r   <= in_operation;
      req_r  <= in_requester;
      page_r <= in_page_number;
    end
    req_head_r <= req_head_nxt;
    don_head_r <= don_head_nxt;
    don_r      <= don_nxt;
    scan_r     <= scan_nxt;
    left_r     <= left_nxt;
    res_r      <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE) && res_free;
  assign res       = res_r;

endmodule
`default_nettype wire

[rtl/core/per_cpu_page_allocator_with_stealing.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_stealing
// Per-requester LIFO free-page lists linked through a next-page memory,
// with batch stealing from the first non-empty donor on an empty allocate.
// ----------------------------------------------------------------------------
// A free or a rejected word passes the start and done states; an allocate
// also reads its head page's link and writes the head back; an empty one
// first scans for a donor, moves pages one by one, then writes the donor head.
// One word is in work at a time; the output register lets the next word in
// while a result still waits. Reset empties every list and loads the register
// defaults; the link memory needs no clearing.
module per_cpu_page_allocator_with_stealing #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [pcpa_pkg::CPU_W-1:0]     in_requester,
  input  wire logic [pcpa_pkg::PAGE_W-1:0]    in_page_number,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pcpa_pkg::PAGE_W-1:0]         out_granted_page,
  output logic [1:0]                          out_status,
  input  wire logic                           cfg_wr_en,
  input  wire logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pcpa_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import pcpa_pkg::*;

  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int LW = PW + 1;

  cfg_t  cfg_r;
  logic  out_valid_r;
  res_t  out_res_r;

  logic  seq_idle, res_free, res_valid, in_accept;
  res_t  res;

  logic [CW-1:0] hd_rd_idx, hd_wr_idx;
  logic [LW-1:0] hd_rd_head, hd_wr_head;
  logic          hd_wr_en;
  logic          lk_rd_en, lk_wr_en;
  logic [PW-1:0] lk_rd_addr, lk_wr_addr;
  logic [LW-1:0] lk_rd_data, lk_wr_data;

  assign in_stall  = !seq_idle;
  assign in_accept = in_valid && !in_stall;
  assign res_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_page  <= FIRST_PAGE_RST;
      cfg_r.page_limit  <= PAGE_LIMIT_RST;
      cfg_r.steal_batch <= STEAL_BATCH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_PAGE:  cfg_r.first_page  <= cfg_wdata[PAGE_W-1:0];
        CFG_PAGE_LIMIT:  cfg_r.page_limit  <= cfg_wdata[LIMIT_W-1:0];
        CFG_STEAL_BATCH: cfg_r.steal_batch <= cfg_wdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = out_res_r.granted_page;
  assign out_status       = out_res_r.status;

  pcpa_seq #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .CW        (CW),
    .PW        (PW),
    .LW        (LW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_operation   (in_operation),
    .in_requester   (in_requester),
    .in_page_number (in_page_number),
    .cfg            (cfg_r),
    .idle           (seq_idle),
    .res_free       (res_free),
    .res_valid      (res_valid),
    .res            (res),
    .hd_rd_idx      (hd_rd_idx),
    .hd_rd_head     (hd_rd_head),
    .hd_wr_en       (hd_wr_en),
    .hd_wr_idx      (hd_wr_idx),
    .hd_wr_head     (hd_wr_head),
    .lk_rd_en       (lk_rd_en),
    .lk_rd_addr     (lk_rd_addr),
    .lk_rd_data     (lk_rd_data),
    .lk_wr_en       (lk_wr_en),
    .lk_wr_addr     (lk_wr_addr),
    .lk_wr_data     (lk_wr_data)
  );

  pcpa_head_file #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .CW        (CW),
    .LW        (LW)
  ) u_head_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (hd_rd_idx),
    .rd_head (hd_rd_head),
    .wr_en   (hd_wr_en),
    .wr_idx  (hd_wr_idx),
    .wr_head (hd_wr_head)
  );

  pcpa_link_ram #(
    .DEPTH (NUM_PAGES),
    .AW    (PW),
    .DW    (LW)
  ) u_link_ram (
    .clk     (clk),
    .rd_en   (lk_rd_en),
    .rd_addr (lk_rd_addr),
    .rd_data (lk_rd_data),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data)
  );

endmodule
`default_nettype wire

[tb/sv/per_cpu_page_allocator_with_stealing_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_stealing_tb
// Self-checking bench for the per-CPU page allocator. Frees and allocates are
// offered from a queue under several register settings and idling patterns.
// A local model of the free lists predicts each result word. Results are
// compared in order against those predictions.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_with_stealing_tb;
  import pcpa_pkg::*;

  localparam int NUM_CPUS  = 8;
  localparam int NUM_PAGES = 1024;
  localparam logic [LIMIT_W-1:0] LIST_END = 11'd1024;
  localparam int PEND_DEPTH = 8;
  localparam int SETTLE_CYCLES = 2 * NUM_CPUS + 12;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic              op;
    logic [CPU_W-1:0]  cpu;
    logic [PAGE_W-1:0] page;
  } alloc_req_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = OP_ALLOC;
  logic [CPU_W-1:0]     in_requester = '0;
  logic [PAGE_W-1:0]    in_page_number = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PAGE_W-1:0]    out_granted_page;
  logic [1:0]           out_status;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_PAGE;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // Local copy of the allocator state and registers.
  logic [LIMIT_W-1:0] head_of [NUM_CPUS];
  logic [LIMIT_W-1:0] link_mem [NUM_PAGES];
  logic [PAGE_W-1:0]  cfg_first = FIRST_PAGE_RST;
  logic [LIMIT_W-1:0] cfg_limit = PAGE_LIMIT_RST;
  logic [BATCH_W-1:0] cfg_batch = STEAL_BATCH_RST;

  alloc_req_t  pend_q[$];
  res_t        expected_q[$];
  logic [PAGE_W-1:0] handed_out[$];

  idle_mode_t idle_mode = IDLE_NONE;
  int  hold_left = 0;
  int  items_issued = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  bit  word_taken = 1'b0;

  per_cpu_page_allocator_with_stealing #(
    .NUM_CPUS (NUM_CPUS),
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_requester    (in_requester),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted_page(out_granted_page),
    .out_status      (out_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      head_of[i] = LIST_END;
    end
  end

  // Ends of a list and out-of-range links both read as the list end.
  function automatic logic [LIMIT_W-1:0] follow_link(input int unsigned pg);
    if (pg >= NUM_PAGES) return LIST_END;
    return (link_mem[pg] >= NUM_PAGES) ? LIST_END : link_mem[pg];
  endfunction

  function automatic res_t allocator_predict(input alloc_req_t rq);
    res_t        r;
    int unsigned pg;
    int unsigned cpu;
    int unsigned left;
    int unsigned moved;
    bit          donor_found;
    r.granted_page = '0;
    r.status = STAT_OK;
    pg = rq.page;
    cpu = rq.cpu;
    if (rq.op == OP_FREE) begin
      if (cpu >= NUM_CPUS || pg < cfg_first || pg >= cfg_limit || pg >= NUM_PAGES) begin
        r.status = STAT_RANGE;
      end else begin
        link_mem[pg] = head_of[cpu];
        head_of[cpu] = pg[LIMIT_W-1:0];
      end
    end else if (cpu >= NUM_CPUS) begin
      r.status = STAT_OOM;
    end else begin
      if (head_of[cpu] >= NUM_PAGES) begin
        // Only the first non-empty donor in ascending order gives up pages.
        donor_found = 1'b0;
        for (int d = 0; d < NUM_CPUS; d++) begin
          if (!donor_found && d != cpu && head_of[d] < NUM_PAGES) begin
            donor_found = 1'b1;
            left = cfg_batch;
            while (left != 0 && head_of[d] < NUM_PAGES) begin
              moved = head_of[d];
              head_of[d] = follow_link(moved);
              link_mem[moved] = head_of[cpu];
              head_of[cpu] = moved[LIMIT_W-1:0];
              left--;
            end
          end
        end
      end
      if (head_of[cpu] < NUM_PAGES) begin
        r.granted_page = head_of[cpu][PAGE_W-1:0];
        head_of[cpu] = follow_link(head_of[cpu]);
        handed_out.push_back(r.granted_page);
      end else begin
        head_of[cpu] = LIST_END;
        r.status = STAT_OOM;
      end
    end
    return r;
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 56;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 56;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Driver: a new word is presented only when the line is free or the
  // current word was taken at the last rising edge.
  always @(negedge clk) begin
    alloc_req_t rq;
    if (!in_valid || word_taken) begin
      if (pend_q.size() != 0 && !sender_rests()) begin
        rq = pend_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= rq.op;
        in_requester <= rq.cpu;
        in_page_number <= rq.page;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_rests();
    end
  end

  // Monitor: predicts every accepted word and checks every result word.
  always @(posedge clk) begin
    alloc_req_t rq;
    res_t       e;
    if (rst_n) begin
      word_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("unexpected result: page %0d status %0d",
                                out_granted_page, out_status));
        end else begin
          e = expected_q.pop_front();
          results_seen++;
          if (out_granted_page !== e.granted_page || out_status !== e.status) begin
            log_failure($sformatf("mismatch: expected page %0d status %0d, got page %0d status %0d",
                                  e.granted_page, e.status, out_granted_page, out_status));
          end
        end
      end
      if (word_taken) begin
        rq.op = in_operation;
        rq.cpu = in_requester;
        rq.page = in_page_number;
        expected_q.push_back(allocator_predict(rq));
      end
    end else begin
      word_taken = 1'b0;
    end
  end

  task automatic offer(input logic op, input int unsigned cpu, input int unsigned pg);
    alloc_req_t rq;
    while (pend_q.size() >= PEND_DEPTH) @(negedge clk);
    rq.op = op;
    rq.cpu = cpu[CPU_W-1:0];
    rq.page = pg[PAGE_W-1:0];
    pend_q.push_back(rq);
    items_issued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (results_seen != items_issued);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    case (idx)
      CFG_FIRST_PAGE:  cfg_first = val[PAGE_W-1:0];
      CFG_PAGE_LIMIT:  cfg_limit = val[LIMIT_W-1:0];
      CFG_STEAL_BATCH: cfg_batch = val[BATCH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int unsigned fp, input int unsigned lim,
                            input int unsigned sb);
    wait_drained();
    write_reg(CFG_FIRST_PAGE, fp);
    write_reg(CFG_PAGE_LIMIT, lim);
    write_reg(CFG_STEAL_BATCH, sb);
  endtask

  // Allocates, frees of pages that were handed out, so lists keep a sane shape,
  // and frees of arbitrary pages, which may be doubles or rejects.
  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    int unsigned lo;
    int unsigned hi;
    int unsigned pg;
    pick = $urandom_range(0, 99);
    lo = cfg_first;
    hi = (cfg_limit < NUM_PAGES) ? cfg_limit : NUM_PAGES;
    if (pick < 45) begin
      offer(OP_ALLOC, $urandom_range(0, NUM_CPUS - 1), $urandom_range(0, NUM_PAGES - 1));
    end else if (pick < 85) begin
      if (handed_out.size() != 0) begin
        idx = $urandom_range(0, handed_out.size() - 1);
        pg = handed_out[idx];
        handed_out.delete(idx);
      end else if (hi > lo) begin
        pg = $urandom_range(lo, hi - 1);
      end else begin
        pg = $urandom_range(0, NUM_PAGES - 1);
      end
      offer(OP_FREE, $urandom_range(0, NUM_CPUS - 1), pg);
    end else begin
      offer(OP_FREE, $urandom_range(0, NUM_CPUS - 1), $urandom_range(0, NUM_PAGES - 1));
    end
  endtask

  task automatic run_phase(input int unsigned fp, input int unsigned lim,
                           input int unsigned sb, input idle_mode_t mode,
                           input int n, input int hold, input bit pause_mid);
    int unsigned lo;
    int unsigned hi;
    int unsigned fill;
    int unsigned base;
    set_config(fp, lim, sb);
    idle_mode = mode;
    hold_left = hold;
    lo = fp;
    hi = (lim < NUM_PAGES) ? lim : NUM_PAGES;
    if (hi > lo) begin
      fill = $urandom_range(8, 32);
      base = $urandom_range(0, hi - lo - 1);
      for (int k = 0; k < fill; k++) begin
        offer(OP_FREE, $urandom_range(0, NUM_CPUS - 1), lo + (base + k) % (hi - lo));
      end
    end
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) wait_drained();
      random_item();
    end
  endtask

  initial begin
    int unsigned fp;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: empty lists, stealing, a self-looped list.
    offer(OP_ALLOC, 0, 0);
    offer(OP_FREE, 0, 0);
    offer(OP_FREE, 7, 1023);
    offer(OP_FREE, 3, 5);
    offer(OP_FREE, 3, 6);
    offer(OP_ALLOC, 0, 1023);
    offer(OP_ALLOC, 0, 0);
    offer(OP_ALLOC, 1, 0);
    offer(OP_ALLOC, 1, 0);
    offer(OP_ALLOC, 1, 0);
    offer(OP_FREE, 2, 10);
    offer(OP_FREE, 2, 10);
    offer(OP_ALLOC, 4, 682);
    offer(OP_FREE, 6, 341);
    // Range bounds, then a batch of one.
    set_config(100, 200, 1);
    offer(OP_FREE, 1, 99);
    offer(OP_FREE, 1, 100);
    offer(OP_FREE, 1, 199);
    offer(OP_FREE, 1, 200);
    offer(OP_ALLOC, 5, 0);
    // Highest first page, widest limit, and a batch of zero.
    set_config(1023, 2047, 0);
    offer(OP_FREE, 5, 1022);
    offer(OP_FREE, 5, 1023);
    offer(OP_ALLOC, 6, 0);
    offer(OP_ALLOC, 6, 0);
    offer(OP_ALLOC, 5, 0);

    run_phase(0, 1024, 64, IDLE_NONE, 350, 300, 1'b0);
    run_phase(0, 1024, 1, IDLE_SEND, 350, 0, 1'b0);
    run_phase(200, 600, 8, IDLE_RECV, 350, 0, 1'b1);
    run_phase(0, 1024, 1024, IDLE_BOTH, 300, 0, 1'b0);
    fp = $urandom_range(0, 300);
    run_phase(fp, $urandom_range(fp + 50, 1024), $urandom_range(1, 16), IDLE_NONE,
              300, 0, 1'b0);
    run_phase(0, 2047, 2047, IDLE_SEND, 150, 0, 1'b0);
    run_phase(0, 0, 3, IDLE_BOTH, 100, 0, 1'b0);

    wait_drained();
    if (expected_q.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (fail_count == 0) begin
      $display("per_cpu_page_allocator_with_stealing test passed");
    end else begin
      $display("per_cpu_page_allocator_with_stealing test failed");
    end
    $finish;
  end

  initial begin
    #(1_000_000_000);
    $display("per_cpu_page_allocator_with_stealing test failed");
    $finish;
  end

endmodule
